// ===== hdl/id_pool_allocator_unit_macros.svh =====
// Assertion macros for the identifier pool allocator.
// Used by the RTL files that carry concurrent checks; depends on nothing.
`ifndef ID_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define ID_POOL_ALLOCATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge, masked while reset is active.
`define IPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("id pool allocator: assertion failed");
// Check on every clock edge, including during reset.
`define IPA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("id pool allocator: assertion failed");
`else
`define IPA_ASSERT(lbl, prop)
`define IPA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/ipa_pkg.sv =====
// Shared constants for the identifier pool allocator.
// No dependencies; imported by the top level.
package ipa_pkg;

  // Pool geometry
  localparam int unsigned POOL_SIZE = 1024;
  localparam int unsigned ID_W      = 10;
  localparam int unsigned ADDR_W    = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W     = $clog2(POOL_SIZE + 1);

  // Request operations
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_INVALID   = 2'd2;

endpackage

// ===== hdl/ipa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ipa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/id_pool_allocator_unit.sv =====
// Flow: a request is accepted in S_IDLE, which issues the free stack and live map reads;
// the result is then registered from S_EXEC and held until it is taken.
// Requests: one in flight at a time; a new request is accepted only in S_IDLE, once the
// result register is free or draining. The update and write-back are done in S_EXEC.
// Reset: asynchronous, active low; afterwards a clearing pass walks the live map,
// one entry a cycle, with s_axis_tready_o held low.
// Top level; depends on ipa_pkg, ipa_ram and id_pool_allocator_unit_macros.svh.
`include "id_pool_allocator_unit_macros.svh"
module id_pool_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] target_id, [15:10] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  // result side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [1:0] status, [11:2] granted_id, [12] is_live
);
  import ipa_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  free_depth_q, free_depth_d;
  logic [CNT_W-1:0]  next_fresh_q, next_fresh_d;
  logic [1:0]        mode_q, mode_d;
  logic [ID_W-1:0]   tid_q, tid_d;
  logic              out_vld_q, out_vld_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic              out_live_q, out_live_d;

  logic              accept;
  logic [CNT_W-1:0]  depth_m1;
  logic              in_range;

  logic              stk_we;
  logic [ADDR_W-1:0] stk_waddr;
  logic [ID_W-1:0]   stk_wdata;
  logic [ADDR_W-1:0] stk_raddr;
  logic [ID_W-1:0]   stk_rdata;

  logic              live_we;
  logic [ADDR_W-1:0] live_waddr;
  logic              live_wdata;
  logic [ADDR_W-1:0] live_raddr;
  logic              live_rdata;

  // handshake: one request in flight, output register free or draining
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_vld_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // read addresses issued at accept time
  assign depth_m1   = free_depth_q - CNT_W'(1);
  assign stk_raddr  = depth_m1[ADDR_W-1:0];
  assign live_raddr = s_axis_tdata_i[ADDR_W-1:0];

  assign in_range = (CNT_W'(tid_q) < CNT_W'(POOL_SIZE));

  // free stack memory
  ipa_ram #(.WIDTH(ID_W), .DEPTH(POOL_SIZE)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (accept),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // live flag memory
  ipa_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_live_ram (
    .clk_i  (clk_i),
    .we_i   (live_we),
    .waddr_i(live_waddr),
    .wdata_i(live_wdata),
    .re_i   (accept),
    .raddr_i(live_raddr),
    .rdata_o(live_rdata)
  );

  // sequencer, request decode and write-back
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    free_depth_d = free_depth_q;
    next_fresh_d = next_fresh_q;
    mode_d       = mode_q;
    tid_d        = tid_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_live_d   = out_live_q;

    stk_we     = 1'b0;
    stk_waddr  = free_depth_q[ADDR_W-1:0];
    stk_wdata  = tid_q;
    live_we    = 1'b0;
    live_waddr = clr_q;
    live_wdata = 1'b0;

    // result register drains when taken
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        live_we = 1'b1;
        clr_d   = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(POOL_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d  = s_axis_tuser_i;
          tid_d   = s_axis_tdata_i[ID_W-1:0];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d      = S_IDLE;
        out_vld_d    = 1'b1;
        out_status_d = STAT_INVALID;
        out_id_d     = '0;
        out_live_d   = 1'b0;
        unique case (mode_q)
          MODE_ALLOC: begin
            // pop the most recent release, else take a fresh id
            if (free_depth_q != '0) begin
              free_depth_d = depth_m1;
              out_id_d     = stk_rdata;
              out_status_d = STAT_OK;
            end else if (next_fresh_q < CNT_W'(POOL_SIZE)) begin
              next_fresh_d = next_fresh_q + CNT_W'(1);
              out_id_d     = next_fresh_q[ID_W-1:0];
              out_status_d = STAT_OK;
            end else begin
              out_status_d = STAT_EXHAUSTED;
            end
            if (out_status_d == STAT_OK) begin
              live_we    = 1'b1;
              live_waddr = out_id_d[ADDR_W-1:0];
              live_wdata = 1'b1;
            end
          end
          MODE_RELEASE: begin
            // only a live, in-range id goes back on the stack
            if (in_range && live_rdata && (free_depth_q < CNT_W'(POOL_SIZE))) begin
              live_we      = 1'b1;
              live_waddr   = tid_q[ADDR_W-1:0];
              live_wdata   = 1'b0;
              stk_we       = 1'b1;
              free_depth_d = free_depth_q + CNT_W'(1);
              out_status_d = STAT_OK;
            end
          end
          MODE_QUERY: begin
            if (in_range) begin
              out_status_d = STAT_OK;
              out_live_d   = live_rdata;
            end
          end
          default: begin
            out_status_d = STAT_INVALID;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      free_depth_q <= '0;
      next_fresh_q <= '0;
      mode_q       <= '0;
      tid_q        <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= '0;
      out_id_q     <= '0;
      out_live_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      free_depth_q <= free_depth_d;
      next_fresh_q <= next_fresh_d;
      mode_q       <= mode_d;
      tid_q        <= tid_d;
      out_vld_q    <= out_vld_d;
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_live_q   <= out_live_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_live_q, out_id_q, out_status_q};

  // checks
  `IPA_ASSERT(a_no_accept_in_clear, (state_q == S_CLEAR) |-> !s_axis_tready_o)
  `IPA_ASSERT(a_exec_loads_result, (state_q == S_EXEC) |=> out_vld_q)
  `IPA_ASSERT(a_fresh_bound, next_fresh_q <= CNT_W'(POOL_SIZE))
  `IPA_ASSERT(a_depth_le_fresh, free_depth_q <= next_fresh_q)

endmodule
